// File: sv/teoq_pkg.sv
package teoq_pkg;

	localparam int QUEUE_DEPTH_DEFAULT = 16;
	localparam int OCC_W = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	// One stored event; the time is the sort key.
	typedef struct packed {
		logic [1:0]  event_type;
		logic [31:0] event_time;
		logic [7:0]  customer_tag;
	} entry_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [1:0]  event_type;
		logic [31:0] event_time;
		logic [7:0]  customer_tag;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [1:0]       head_type;
		logic [31:0]      head_time;
		logic [7:0]       head_tag;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

	// Operation broadcast to every cell of the row.
	typedef struct packed {
		logic insert;
		logic remove;
	} cell_ctl_t;

endpackage

// File: sv/teoq_req_if.sv
interface teoq_req_if;
	logic             valid;
	logic             ready;
	teoq_pkg::req_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: sv/teoq_rsp_if.sv
interface teoq_rsp_if;
	logic             valid;
	logic             ready;
	teoq_pkg::rsp_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: sv/teoq_cell.sv
module teoq_cell (
	input  logic                clk,
	input  teoq_pkg::cell_ctl_t ctl,
	input  logic                occupied,
	input  logic                is_tail,
	input  teoq_pkg::entry_t    fresh,
	input  teoq_pkg::entry_t    left_entry,
	input  logic                left_gt,
	input  teoq_pkg::entry_t    right_entry,
	output teoq_pkg::entry_t    entry,
	output logic                gt
);

	teoq_pkg::entry_t entry_q;
	teoq_pkg::entry_t entry_d;

	// A stored entry later than the new one has to move one place back.
	assign gt = occupied && (entry_q.event_time > fresh.event_time);

	always_comb begin
		entry_d = entry_q;
		if (ctl.insert) begin
			if (left_gt) begin
				entry_d = left_entry;
			end else if (gt || is_tail) begin
				entry_d = fresh;
			end
		end else if (ctl.remove) begin
			entry_d = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

// File: sv/time_ordered_event_queue_core.sv
// Time-ordered event queue: a sorted list of up to QUEUE_DEPTH events (type, time,
// customer tag) held in a row of cells, the earliest time at the head. An insert
// request places the event behind every stored event with an equal or earlier time,
// so equal times leave first in, first out; a remove request returns the head event.
// Every request gives exactly one response with a status (ok, underflow on a remove
// from an empty queue, overflow on an insert into a full queue, which drops the event)
// and the occupancy after the operation. All cells compare their time with the new one
// in parallel and shift toward their neighbor in the same cycle, so a new request is
// taken every cycle while the response register is free or being emptied. There is no
// clearing pass after reset; the contents of an unoccupied cell are never shown.
module time_ordered_event_queue_core #(
	parameter int QUEUE_DEPTH = teoq_pkg::QUEUE_DEPTH_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	teoq_req_if.sink   req,
	teoq_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	logic              rsp_valid_q;
	teoq_pkg::rsp_t    rsp_q;
	teoq_pkg::rsp_t    rsp_d;
	logic              accept;
	logic              full;
	logic              empty;
	teoq_pkg::cell_ctl_t ctl;
	teoq_pkg::entry_t  fresh;
	teoq_pkg::entry_t  cell_entry [QUEUE_DEPTH];
	logic              cell_gt [QUEUE_DEPTH];

	// The response register frees itself in the same cycle it is read, so the
	// queue only stalls while a finished response is still waiting.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	assign fresh.event_type   = req.payload.event_type;
	assign fresh.event_time   = req.payload.event_time;
	assign fresh.customer_tag = req.payload.customer_tag;

	assign ctl.insert = accept && (req.payload.opcode == teoq_pkg::OP_INSERT) && !full;
	assign ctl.remove = accept && (req.payload.opcode == teoq_pkg::OP_REMOVE) && !empty;

	// Row of cells. Each one sees the new event and its two neighbors; cell zero
	// is the head, the cell at the current count is the first free place.
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
		teoq_pkg::entry_t left_entry;
		teoq_pkg::entry_t right_entry;
		logic             left_gt;

		if (g == 0) begin : g_head
			assign left_entry = fresh;
			assign left_gt    = 1'b0;
		end else begin : g_mid
			assign left_entry = cell_entry[g-1];
			assign left_gt    = cell_gt[g-1];
		end

		if (g == QUEUE_DEPTH - 1) begin : g_last
			assign right_entry = cell_entry[g];
		end else begin : g_inner
			assign right_entry = cell_entry[g+1];
		end

		teoq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (IDX < count_q),
			.is_tail     (IDX == count_q),
			.fresh       (fresh),
			.left_entry  (left_entry),
			.left_gt     (left_gt),
			.right_entry (right_entry),
			.entry       (cell_entry[g]),
			.gt          (cell_gt[g])
		);
	end

	always_comb begin
		count_d = count_q;
		if (ctl.insert) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctl.remove) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// The response reports the head as it stood before the shift.
	always_comb begin
		rsp_d           = '0;
		rsp_d.status    = teoq_pkg::ST_OK;
		rsp_d.occupancy = teoq_pkg::OCC_W'(count_d);
		if (req.payload.opcode == teoq_pkg::OP_INSERT) begin
			if (full) begin
				rsp_d.status = teoq_pkg::ST_OVERFLOW;
			end
		end else if (empty) begin
			rsp_d.status = teoq_pkg::ST_UNDERFLOW;
		end else begin
			rsp_d.head_type = cell_entry[0].event_type;
			rsp_d.head_time = cell_entry[0].event_time;
			rsp_d.head_tag  = cell_entry[0].customer_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the time-ordered event queue. Every request that the
// queue accepts is run through a behavioral copy of the sorted event list kept
// here; the outcome it gives is queued and compared, field by field, with each
// response that leaves the queue. A short directed table comes first. A long
// random part follows, made of bursts that lean toward inserts or removes so the
// list keeps running into full and empty.
module testbench;

	import teoq_pkg::*;

	localparam int QUEUE_DEPTH    = QUEUE_DEPTH_DEFAULT;
	localparam int RANDOM_ITEMS   = 1950;
	// The response is registered behind the request, so a short settle is
	// enough to catch a stray response after the last expected one.
	localparam int DRAIN_CYCLES   = 16;
	// The longest quiet stretch in a correct run is a long sender gap that
	// overlaps a long receiver stall.
	localparam int WATCHDOG_LIMIT = 1000;

	// One row of the directed table. Where the outcome is obvious it is typed
	// in, and that value is checked instead of the predicted one.
	typedef struct {
		req_t request;
		bit   known_given;
		rsp_t known;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;

	teoq_req_if req_ch ();
	teoq_rsp_if rsp_ch ();

	time_ordered_event_queue_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Behavioral event list: position 0 holds the earliest event.
	entry_t        sched_entries [QUEUE_DEPTH];
	int unsigned   sched_count;
	rsp_t          predicted_outcomes [$];
	directed_row_t directed_rows [$];

	// When set, the sender leaves no gap and offers a new request on every cycle that the queue is ready.
	bit sender_quiet;

	int unsigned mismatches;
	int unsigned responses_checked;
	int unsigned inserts_seen, overflows_seen, removes_seen, underflows_seen;
	int unsigned peak_occupancy;
	int unsigned idle_cycles;

	// Applies one request to the event list and returns the response it causes.
	// An insert walks back from the tail past every entry with a strictly later
	// time, so an entry with an equal time stays ahead of the new one.
	function automatic rsp_t apply_to_event_list(req_t r);
		rsp_t        res;
		entry_t      fresh;
		int unsigned pos;
		res = '0;
		res.status = ST_OK;
		if (r.opcode == OP_INSERT) begin
			if (sched_count >= QUEUE_DEPTH) begin
				res.status = ST_OVERFLOW;
			end else begin
				fresh.event_type   = r.event_type;
				fresh.event_time   = r.event_time;
				fresh.customer_tag = r.customer_tag;
				pos = sched_count;
				while (pos > 0 && sched_entries[pos-1].event_time > r.event_time) begin
					sched_entries[pos] = sched_entries[pos-1];
					pos--;
				end
				sched_entries[pos] = fresh;
				sched_count++;
			end
		end else if (sched_count == 0) begin
			res.status = ST_UNDERFLOW;
		end else begin
			res.head_type = sched_entries[0].event_type;
			res.head_time = sched_entries[0].event_time;
			res.head_tag  = sched_entries[0].customer_tag;
			for (int i = 1; i < sched_count; i++)
				sched_entries[i-1] = sched_entries[i];
			sched_count--;
		end
		res.occupancy = sched_count[OCC_W-1:0];
		return res;
	endfunction

	// Idle length for either side: mostly none, often short, rarely long.
	function automatic int unsigned idle_length();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic void stage_directed(opcode_t op, logic [1:0] ty, logic [31:0] tm,
			logic [7:0] tg, bit known_given = 1'b0, status_t st = ST_OK,
			logic [1:0] h_ty = '0, logic [31:0] h_tm = '0, logic [7:0] h_tg = '0,
			logic [OCC_W-1:0] occ = '0);
		directed_row_t row;
		row.request.opcode       = op;
		row.request.event_type   = ty;
		row.request.event_time   = tm;
		row.request.customer_tag = tg;
		row.known_given          = known_given;
		row.known.status         = st;
		row.known.head_type      = h_ty;
		row.known.head_time      = h_tm;
		row.known.head_tag       = h_tg;
		row.known.occupancy      = occ;
		directed_rows.push_back(row);
	endfunction

	// Offers one request, after an optional gap, and holds it until the queue
	// takes it. The response it should cause is queued at the accepting edge.
	task automatic issue_request(req_t r, bit known_given, rsp_t known);
		rsp_t        predicted;
		int unsigned gap;
		gap = sender_quiet ? 0 : idle_length();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= r;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		predicted = apply_to_event_list(r);
		predicted_outcomes.push_back(known_given ? known : predicted);
		if (r.opcode == OP_INSERT) begin
			inserts_seen++;
			if (predicted.status == ST_OVERFLOW)
				overflows_seen++;
		end else begin
			removes_seen++;
			if (predicted.status == ST_UNDERFLOW)
				underflows_seen++;
		end
		if (sched_count > peak_occupancy)
			peak_occupancy = sched_count;
	endtask

	// Response side: ready is held high for runs of random length, now and then
	// for a long stretch, with stalls of random length in between.
	initial begin
		int unsigned stall;
		forever begin
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if ($urandom_range(0, 9) == 0)
				repeat (200) @(posedge clk);
			stall = idle_length();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Every response is checked against the oldest outcome still waiting.
	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.payload;
			if (predicted_outcomes.size() == 0) begin
				$error("response with no request outstanding: status %0d occupancy %0d",
					got.status, got.occupancy);
				mismatches++;
			end else begin
				want = predicted_outcomes.pop_front();
				responses_checked++;
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					mismatches++;
				end
				if (got.head_type !== want.head_type) begin
					$error("head_type: expected %0d, got %0d", want.head_type, got.head_type);
					mismatches++;
				end
				if (got.head_time !== want.head_time) begin
					$error("head_time: expected %0h, got %0h", want.head_time, got.head_time);
					mismatches++;
				end
				if (got.head_tag !== want.head_tag) begin
					$error("head_tag: expected %0h, got %0h", want.head_tag, got.head_tag);
					mismatches++;
				end
				if (got.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
					mismatches++;
				end
			end
		end
	end

	// A run that stops moving in either direction is stuck.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("time_ordered_event_queue_core verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		req_t        r;
		int unsigned random_sent;
		int unsigned burst_len;
		int unsigned insert_pct;
		int unsigned time_mode;
		logic [31:0] base_time;

		arst_n         <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.payload <= '0;
		sender_quiet   = 1'b0;
		sched_count    = 0;
		idle_cycles    = 0;

		// A remove on an empty queue, with junk in the fields it ignores.
		stage_directed(OP_REMOVE, 2'd3, 32'hDEAD_BEEF, 8'h5A, 1'b1, ST_UNDERFLOW);
		// Largest and smallest keys; the smaller one must come out first.
		stage_directed(OP_INSERT, 2'd3, 32'hFFFF_FFFF, 8'hFF, 1'b1, ST_OK, 0, 0, 0, 5'd1);
		stage_directed(OP_INSERT, 2'd0, 32'h0000_0000, 8'h00, 1'b1, ST_OK, 0, 0, 0, 5'd2);
		stage_directed(OP_REMOVE, 2'd0, 32'h0, 8'h0, 1'b1, ST_OK, 2'd0, 32'h0, 8'h00, 5'd1);
		stage_directed(OP_REMOVE, 2'd0, 32'h0, 8'h0, 1'b1, ST_OK,
			2'd3, 32'hFFFF_FFFF, 8'hFF, 5'd0);
		stage_directed(OP_REMOVE, 2'd0, 32'h0, 8'h0, 1'b1, ST_UNDERFLOW);
		// Two equal times, then an earlier one that must jump ahead of both.
		stage_directed(OP_INSERT, 2'd1, 32'd100, 8'h01);
		stage_directed(OP_INSERT, 2'd2, 32'd100, 8'h02);
		stage_directed(OP_INSERT, 2'd1, 32'd50, 8'h03);
		// Fill to the top with a mix of repeated and decreasing times.
		for (int k = 0; k < QUEUE_DEPTH - 3; k++)
			stage_directed(OP_INSERT, 2'(k), 32'(200 - 25 * (k % 5)), 8'(8'h10 + k));
		// An insert into the full queue is dropped.
		stage_directed(OP_INSERT, 2'd2, 32'd1, 8'hAA, 1'b1, ST_OVERFLOW, 0, 0, 0, 5'd16);
		stage_directed(OP_REMOVE, 2'd0, 32'h0, 8'h0);
		stage_directed(OP_REMOVE, 2'd0, 32'h0, 8'h0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue_request(directed_rows[i].request, directed_rows[i].known_given,
				directed_rows[i].known);

		// Random bursts. Each burst picks a lean toward inserts or removes, so the
		// list swings between empty and full, and a way of choosing times: fully
		// random, clustered around one base so equal times are common, or the
		// extremes of the field.
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			burst_len = $urandom_range(8, 120);
			case ($urandom_range(0, 4))
				0: insert_pct = 95;
				1: insert_pct = 75;
				2: insert_pct = 50;
				3: insert_pct = 25;
				default: insert_pct = 5;
			endcase
			time_mode    = $urandom_range(0, 2);
			base_time    = $urandom();
			sender_quiet = ($urandom_range(0, 3) == 0);
			repeat (burst_len) begin
				r.opcode       = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
				r.event_type   = 2'($urandom_range(0, 3));
				r.customer_tag = 8'($urandom_range(0, 255));
				case (time_mode)
					0: r.event_time = $urandom();
					1: r.event_time = base_time + $urandom_range(0, 7);
					default: begin
						case ($urandom_range(0, 3))
							0: r.event_time = 32'h0000_0000;
							1: r.event_time = 32'h0000_0001;
							2: r.event_time = 32'hFFFF_FFFE;
							default: r.event_time = 32'hFFFF_FFFF;
						endcase
					end
				endcase
				issue_request(r, 1'b0, '0);
				random_sent++;
			end
		end

		req_ch.valid <= 1'b0;
		while (predicted_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d inserts (%0d dropped on a full queue) and %0d removes %s",
			inserts_seen, overflows_seen, removes_seen,
			$sformatf("(%0d on an empty queue).", underflows_seen));
		$display("Checked %0d responses, peak occupancy %0d, %0d mismatching fields.",
			responses_checked, peak_occupancy, mismatches);
		if (mismatches == 0) begin
			$display("time_ordered_event_queue_core verification clean");
		end else begin
			$display("time_ordered_event_queue_core verification failed");
		end
		$finish;
	end

endmodule
